// ===== rtl/art_pkg.sv =====
// Package for the retransmission table: types, codes and constants.
package art_pkg;

	localparam int SLOTS_DEF   = 8;
	localparam int MAX_RES     = 8;
	localparam int BASE_NOREL  = 600;
	localparam int JIT_MOD     = 400;
	localparam int TRY_STEP    = 300;
	localparam int JIT_STEPS   = 16;
	localparam logic [31:0] SEED = 32'h1;

	typedef enum logic [1:0] {
		REQ_SEND = 2'd0,
		REQ_ACK  = 2'd1,
		REQ_TICK = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		K_ACCEPTED = 3'd0,
		K_FULL     = 3'd1,
		K_TRANSMIT = 3'd2,
		K_GIVE_UP  = 3'd3,
		K_IDLE     = 3'd4,
		K_ACK_DONE = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		CFG_RELIABILITY = 2'd0,
		CFG_MAX_RETRIES = 2'd1,
		CFG_ACK_TIMEOUT = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SEND, S_ARD, S_AEVAL, S_AEND,
		S_TRD, S_TEVAL, S_TJIT, S_TUPD, S_TEND
	} state_t;

	typedef struct packed {
		logic [15:0] dest;
		logic [31:0] id;
		logic [7:0]  tries;
		logic [31:0] due;
	} entry_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  slot;
		logic [15:0] dst;
		logic [31:0] msg_id;
		logic        first;
		logic [3:0]  freed;
		logic        last;
	} res_t;

	function automatic logic [31:0] xorshift(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x << 13);
		y = y ^ (y >> 17);
		y = y ^ (y << 5);
		return y;
	endfunction

endpackage

// ===== rtl/ack_retransmit_table_top.sv =====
// Retransmission table: slot memory, scan sequencer and jitter reduction.
// Send: the result is registered from the send state, which waits while the output stalls.
// Ack: scans every slot, reading each used slot before it is evaluated. Tick: scans
// every slot; a due entry that does not give up goes through the 16-step mod-400
// jitter unit; at most 8 results per tick. One item at a time.
// Output register takes the result, so a new item is taken while it waits.
// Reset clears used bits and sets the control registers to defaults; entries need no clearing.
module ack_retransmit_table_top #(
	parameter int SLOTS = art_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [15:0] dst,
	input  logic [31:0] msg_id,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [2:0]  slot,
	output logic [15:0] out_dst,
	output logic [31:0] out_msg_id,
	output logic        first_attempt,
	output logic [3:0]  freed_count,
	output logic        last
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	art_pkg::state_t state_q, state_d;

	logic        rel_q;
	logic [7:0]  max_q;
	logic [19:0] tmo_q;

	logic [15:0] dst_q;
	logic [31:0] id_q;
	logic [31:0] now_q;

	logic [SLOTS-1:0] used_q;
	logic [IW-1:0]    idx_q;
	logic [3:0]       cnt_q;
	logic [3:0]       freed_q;
	logic [31:0]      rnd_q;
	logic [31:0]      jx_q;
	logic [8:0]       jr_q;
	logic [3:0]       step_q;
	logic [7:0]       tinc_q;
	logic [31:0]      part_q;

	art_pkg::entry_t mem [SLOTS];
	art_pkg::entry_t rd_q;

	art_pkg::res_t pend_q, out_q;
	logic          pend_v_q, out_v_q;

	// control from the sequencer
	logic            emit_ok, ld_out, pend_ld, pend_clr, mem_we, set_used, clr_used;
	logic            adv, start_jit, fr_inc;
	logic [IW-1:0]   mem_wa;
	art_pkg::entry_t mem_wd;
	art_pkg::res_t   out_d, pend_d;

	logic            has_free;
	logic [IW-1:0]   free_idx;
	logic            last_idx, due, give_up, cnt_end;
	logic [31:0]     age;
	logic [7:0]      tinc;
	logic [31:0]     base;
	logic [10:0]     jt;
	logic [8:0]      jr_next;

	assign emit_ok  = !out_v_q || !out_stall;
	assign in_stall = (state_q != art_pkg::S_IDLE);
	assign last_idx = (idx_q == LAST_IDX);
	assign cnt_end  = (cnt_q == 4'(art_pkg::MAX_RES - 1));
	assign age      = now_q - rd_q.due;
	assign due      = !age[31];
	assign give_up  = rel_q && (rd_q.tries >= max_q);
	assign tinc     = (rd_q.tries == 8'hFF) ? 8'hFF : rd_q.tries + 8'd1;
	assign base     = rel_q ? 32'(tmo_q) : 32'(art_pkg::BASE_NOREL);

	// lowest free slot
	always_comb begin
		has_free = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				has_free = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	// two bits of the mod-400 reduction per step
	always_comb begin
		jt = {jr_q, jx_q[31:30]};
		if (jt >= 11'(3 * art_pkg::JIT_MOD))
			jr_next = 9'(jt - 11'(3 * art_pkg::JIT_MOD));
		else if (jt >= 11'(2 * art_pkg::JIT_MOD))
			jr_next = 9'(jt - 11'(2 * art_pkg::JIT_MOD));
		else if (jt >= 11'(art_pkg::JIT_MOD))
			jr_next = 9'(jt - 11'(art_pkg::JIT_MOD));
		else
			jr_next = 9'(jt);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			art_pkg::S_IDLE: begin
				if (in_valid) begin
					case (art_pkg::req_t'(req_type))
						art_pkg::REQ_SEND: state_d = art_pkg::S_SEND;
						art_pkg::REQ_ACK:  state_d = art_pkg::S_ARD;
						art_pkg::REQ_TICK: state_d = art_pkg::S_TRD;
						default:           state_d = art_pkg::S_IDLE;
					endcase
				end
			end
			art_pkg::S_SEND: if (emit_ok) state_d = art_pkg::S_IDLE;
			art_pkg::S_ARD: begin
				if (used_q[idx_q]) state_d = art_pkg::S_AEVAL;
				else if (last_idx) state_d = art_pkg::S_AEND;
			end
			art_pkg::S_AEVAL: state_d = last_idx ? art_pkg::S_AEND : art_pkg::S_ARD;
			art_pkg::S_AEND: if (emit_ok) state_d = art_pkg::S_IDLE;
			art_pkg::S_TRD: begin
				if (used_q[idx_q]) state_d = art_pkg::S_TEVAL;
				else if (last_idx) state_d = art_pkg::S_TEND;
			end
			art_pkg::S_TEVAL: begin
				if (!due)
					state_d = last_idx ? art_pkg::S_TEND : art_pkg::S_TRD;
				else if (give_up) begin
					if (!pend_v_q || emit_ok)
						state_d = (last_idx || cnt_end) ? art_pkg::S_TEND : art_pkg::S_TRD;
				end else
					state_d = art_pkg::S_TJIT;
			end
			art_pkg::S_TJIT: if (step_q == 4'(art_pkg::JIT_STEPS - 1)) state_d = art_pkg::S_TUPD;
			art_pkg::S_TUPD: begin
				if (!pend_v_q || emit_ok)
					state_d = (last_idx || cnt_end) ? art_pkg::S_TEND : art_pkg::S_TRD;
			end
			art_pkg::S_TEND: if (emit_ok) state_d = art_pkg::S_IDLE;
			default: state_d = art_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ld_out    = 1'b0;
		out_d     = '0;
		pend_ld   = 1'b0;
		pend_d    = '0;
		pend_clr  = 1'b0;
		mem_we    = 1'b0;
		mem_wa    = idx_q;
		mem_wd    = '0;
		set_used  = 1'b0;
		clr_used  = 1'b0;
		adv       = 1'b0;
		start_jit = 1'b0;
		fr_inc    = 1'b0;
		case (state_q)
			art_pkg::S_SEND: begin
				if (emit_ok) begin
					ld_out    = 1'b1;
					out_d.last = 1'b1;
					if (has_free) begin
						out_d.kind   = art_pkg::K_ACCEPTED;
						out_d.slot   = 3'(free_idx);
						out_d.dst    = dst_q;
						out_d.msg_id = id_q;
						mem_we       = 1'b1;
						mem_wa       = free_idx;
						mem_wd       = '{dest: dst_q, id: id_q, tries: 8'd0, due: now_q};
						set_used     = 1'b1;
					end else
						out_d.kind = art_pkg::K_FULL;
				end
			end
			art_pkg::S_ARD: if (!used_q[idx_q]) adv = 1'b1;
			art_pkg::S_AEVAL: begin
				adv = 1'b1;
				if (rd_q.id == id_q) begin
					clr_used = 1'b1;
					fr_inc   = 1'b1;
				end
			end
			art_pkg::S_AEND: begin
				if (emit_ok) begin
					ld_out      = 1'b1;
					out_d.kind  = art_pkg::K_ACK_DONE;
					out_d.freed = freed_q;
					out_d.last  = 1'b1;
				end
			end
			art_pkg::S_TRD: if (!used_q[idx_q]) adv = 1'b1;
			art_pkg::S_TEVAL: begin
				if (!due)
					adv = 1'b1;
				else if (give_up) begin
					if (!pend_v_q || emit_ok) begin
						ld_out        = pend_v_q;
						out_d         = pend_q;
						pend_ld       = 1'b1;
						pend_d.kind   = art_pkg::K_GIVE_UP;
						pend_d.slot   = 3'(idx_q);
						pend_d.dst    = rd_q.dest;
						pend_d.msg_id = rd_q.id;
						clr_used      = 1'b1;
						adv           = 1'b1;
					end
				end else
					start_jit = 1'b1;
			end
			art_pkg::S_TUPD: begin
				if (!pend_v_q || emit_ok) begin
					ld_out        = pend_v_q;
					out_d         = pend_q;
					pend_ld       = 1'b1;
					pend_d.kind   = art_pkg::K_TRANSMIT;
					pend_d.slot   = 3'(idx_q);
					pend_d.dst    = rd_q.dest;
					pend_d.msg_id = rd_q.id;
					pend_d.first  = (rd_q.tries == 8'd0);
					mem_we        = 1'b1;
					mem_wd        = '{dest: rd_q.dest, id: rd_q.id, tries: tinc_q,
						due: part_q + 32'(jr_q)};
					adv           = 1'b1;
				end
			end
			art_pkg::S_TEND: begin
				if (emit_ok) begin
					ld_out   = 1'b1;
					pend_clr = 1'b1;
					if (pend_v_q)
						out_d = pend_q;
					else
						out_d.kind = art_pkg::K_IDLE;
					out_d.last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// slot memory: one write port, registered read at the scan index
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_q <= mem[idx_q];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == art_pkg::S_IDLE && in_valid) begin
			dst_q <= dst;
			id_q  <= msg_id;
			now_q <= now_ms;
		end
		if (pend_ld)
			pend_q <= pend_d;
		if (ld_out)
			out_q <= out_d;
		if (start_jit) begin
			tinc_q <= tinc;
			part_q <= now_q + base + 32'(tinc) * 32'(art_pkg::TRY_STEP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= art_pkg::S_IDLE;
			rel_q    <= 1'b1;
			max_q    <= 8'd3;
			tmo_q    <= 20'd2000;
			used_q   <= '0;
			idx_q    <= '0;
			cnt_q    <= '0;
			freed_q  <= '0;
			rnd_q    <= art_pkg::SEED;
			jx_q     <= '0;
			jr_q     <= '0;
			step_q   <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					art_pkg::CFG_RELIABILITY: rel_q <= cfg_data[0];
					art_pkg::CFG_MAX_RETRIES: max_q <= cfg_data[7:0];
					art_pkg::CFG_ACK_TIMEOUT: tmo_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == art_pkg::S_IDLE && in_valid) begin
				idx_q    <= '0;
				cnt_q    <= '0;
				freed_q  <= '0;
				pend_v_q <= 1'b0;
			end
			if (adv && !last_idx)
				idx_q <= idx_q + IW'(1);
			if (set_used)
				used_q[free_idx] <= 1'b1;
			if (clr_used)
				used_q[idx_q] <= 1'b0;
			if (fr_inc && freed_q != 4'hF)
				freed_q <= freed_q + 4'd1;
			if (pend_ld) begin
				pend_v_q <= 1'b1;
				cnt_q    <= cnt_q + 4'd1;
			end else if (pend_clr)
				pend_v_q <= 1'b0;
			// advance the generator once per transmit and start the reduction
			if (start_jit) begin
				rnd_q  <= art_pkg::xorshift(rnd_q);
				jx_q   <= art_pkg::xorshift(rnd_q);
				jr_q   <= '0;
				step_q <= '0;
			end else if (state_q == art_pkg::S_TJIT) begin
				jx_q   <= jx_q << 2;
				jr_q   <= jr_next;
				step_q <= step_q + 4'd1;
			end
			if (ld_out)
				out_v_q <= 1'b1;
			else if (!out_stall)
				out_v_q <= 1'b0;
		end
	end

	assign out_valid     = out_v_q;
	assign kind          = out_q.kind;
	assign slot          = out_q.slot;
	assign out_dst       = out_q.dst;
	assign out_msg_id    = out_q.msg_id;
	assign first_attempt = out_q.first;
	assign freed_count   = out_q.freed;
	assign last          = out_q.last;

endmodule
